/* hw/rtl/lrl_pkg.sv */
package lrl_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DUMP   = 1'b1
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t               command;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] held_key;
        logic                    has_entry;
        logic                    last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DUMP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // item accepted: latch key, hit vector, clear dump index
        logic update;    // apply insert / refresh to the list
        logic emit;      // put one dump result into the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit_last; // the current emit is the final one of the dump
    } dp_status_t;

endpackage

/* hw/rtl/lru_recency_list_unit.sv */
// LRU recency list. Holds up to min(capacity, DEPTH) 32-bit keys, newest
// first (capacity 0 acts as 1). An insert item (command 0) either moves a
// held key to the front or puts a new key at the front, evicting the oldest
// keys as needed; it gives no result. A dump item (command 1) streams every
// held key newest first, one result per cycle, with last set on the final
// one; an empty list gives a single result with has_entry 0, held_key 0.
// Timing: an item is taken when start is high and busy is low. An insert
// keeps busy high through the update state: at accept a parallel compare
// against all entries is registered into the hit vector, and the update
// state then shifts the list. A dump keeps busy high until its final
// result is emitted; its first result goes through the dump state and the
// result register before it shows on result/result_valid, the rest follow
// back to back; the receiver cannot stall, each result is shown for exactly
// one cycle. A new item may be accepted while the final result of a dump is
// still on the outputs. Write capacity (cfg_we/cfg_data) only while idle;
// lowering it trims the list at the next insert of a new key.
module lru_recency_list_unit #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  lrl_pkg::req_t             request,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [lrl_pkg::CAP_W-1:0] cfg_data,
    output logic                      result_valid,
    output lrl_pkg::res_t             result
);

    lrl_pkg::dp_cmd_t    cmd;
    lrl_pkg::dp_status_t status;

    // sequencer: idle / update / dump
    lrl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    // list storage, lookup, shift and result register
    lrl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hw/rtl/lrl_ctrl.sv */
module lrl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lrl_pkg::cmd_code_t  command,
    input  lrl_pkg::dp_status_t status,
    output lrl_pkg::dp_cmd_t    cmd,
    output logic                busy
);

    lrl_pkg::state_t state_reg;
    lrl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (command == lrl_pkg::CMD_DUMP)
                    begin
                        state_next = lrl_pkg::ST_DUMP;
                    end
                    else
                    begin
                        state_next = lrl_pkg::ST_UPDATE;
                    end
                end
            end
            lrl_pkg::ST_UPDATE:
            begin
                state_next = lrl_pkg::ST_IDLE;
            end
            lrl_pkg::ST_DUMP:
            begin
                if (status.emit_last)
                begin
                    state_next = lrl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = (state_reg == lrl_pkg::ST_IDLE) && start;
        cmd.update  = (state_reg == lrl_pkg::ST_UPDATE);
        cmd.emit    = (state_reg == lrl_pkg::ST_DUMP);
        busy        = (state_reg != lrl_pkg::ST_IDLE);
    end

endmodule

/* hw/rtl/lrl_datapath.sv */
module lrl_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrl_pkg::req_t                 request,
    input  logic                          cfg_we,
    input  logic [lrl_pkg::CAP_W-1:0]     cfg_data,
    input  lrl_pkg::dp_cmd_t              cmd,
    output lrl_pkg::dp_status_t           status,
    output logic                          result_valid,
    output lrl_pkg::res_t                 result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = 8;   // wide enough for DEPTH and any capacity code

    logic [lrl_pkg::KEY_W-1:0] entries_reg [DEPTH];
    logic [lrl_pkg::KEY_W-1:0] key_reg;
    logic [DEPTH-1:0]          hit_reg;
    logic [DEPTH-1:0]          hit_next;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             fill_next;
    logic [lrl_pkg::CAP_W-1:0] capacity_reg;
    logic [IW-1:0]             idx_reg;
    logic                      result_valid_reg;
    lrl_pkg::res_t             result_reg;

    logic [CW-1:0]    ecap;
    logic [CW-1:0]    keep;
    logic             any_hit;
    logic [DEPTH-1:0] below;      // a hit sits at a lower index
    logic [DEPTH-1:0] shift_en;
    logic             last_pos;

    // parallel lookup, registered at accept
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (entries_reg[i] == request.key) && (CW'(i) < fill_reg);
        end
    end

    // effective capacity: zero acts as one, clamp to DEPTH
    always_comb
    begin
        if ({{(WW-lrl_pkg::CAP_W){1'b0}}, capacity_reg} > WW'(DEPTH))
        begin
            ecap = CW'(DEPTH);
        end
        else if (capacity_reg == '0)
        begin
            ecap = CW'(1);
        end
        else
        begin
            ecap = CW'(capacity_reg);
        end
    end

    always_comb
    begin
        if (fill_reg > ecap - CW'(1))
        begin
            keep = ecap - CW'(1);
        end
        else
        begin
            keep = fill_reg;
        end
    end

    assign any_hit = |hit_reg;

    always_comb
    begin
        below[0]    = 1'b0;
        shift_en[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            below[i] = below[i-1] | hit_reg[i-1];
        end
        for (int i = 1; i < DEPTH; i++)
        begin
            shift_en[i] = any_hit ? !below[i] : (CW'(i) <= keep);
        end
    end

    assign fill_next = any_hit ? fill_reg : keep + CW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.update && shift_en[0])
        begin
            entries_reg[0] <= key_reg;
        end
        for (int i = 1; i < DEPTH; i++)
        begin
            if (cmd.update && shift_en[i])
            begin
                entries_reg[i] <= entries_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= request.key;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            capacity_reg <= lrl_pkg::CAP_RESET;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    assign last_pos         = (CW'(idx_reg) == fill_reg - CW'(1));
    assign status.emit_last = (fill_reg == '0) || last_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (fill_reg == '0)
            begin
                result_reg.held_key  <= '0;
                result_reg.has_entry <= 1'b0;
                result_reg.last      <= 1'b1;
            end
            else
            begin
                result_reg.held_key  <= entries_reg[idx_reg];
                result_reg.has_entry <= 1'b1;
                result_reg.last      <= last_pos;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hw/rtl/lrl_checker.sv */
module lrl_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input lrl_pkg::req_t request,
    input logic          busy,
    input logic          result_valid,
    input lrl_pkg::res_t result
);

    // busy is high in the cycle after any accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // inserts produce no result
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.command == lrl_pkg::CMD_INSERT |=> !result_valid)
        else $error("result after insert");

    // empty-list result is a single zero item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_entry |-> result.last && result.held_key == '0)
        else $error("malformed empty-list result");

    // dump stream is contiguous until last
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap in dump stream");

endmodule

bind lru_recency_list_unit lrl_checker u_lrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
